FILE: design/bctl_pkg.sv
// Shared constants, command and status types for the bucketed code table lookup.
`default_nettype none

package bctl_pkg;

    localparam int CODE_W          = 24;
    localparam int INDEX_W         = 13;
    localparam int OP_W            = 2;
    localparam int ST_W            = 2;
    localparam int BKT_W           = 8;
    localparam int DEF_MAX_ENTRIES = 8192;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_FOUND   = 2'd1;
    localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_APPEND,
        CMD_BKT_INIT,
        CMD_SWEEP,
        CMD_CNT_A,
        CMD_CNT_B,
        CMD_CNT_C,
        CMD_PFX_A,
        CMD_PFX_B,
        CMD_SCT_A,
        CMD_SCT_B,
        CMD_SCT_C,
        CMD_BUILT,
        CMD_LK_A,
        CMD_LK_B,
        CMD_WK_A,
        CMD_WK_B,
        CMD_WK_NEXT,
        CMD_RESULT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t         op;
        logic [ST_W-1:0] res;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            index_valid;
        logic            bkt_last;
        logic            iter_end;
        logic            remain_zero;
        logic            match;
        logic            out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/bctl_dp.sv
// Datapath: code, order and bucket memories, loop counters and result register.
`default_nettype none

module bctl_dp import bctl_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_stat_t                stat,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [CODE_W-1:0]  code,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [ST_W-1:0]         status,
    output logic [INDEX_W-1:0]      index
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NB = 1 << BKT_W;

    logic [CODE_W-1:0] code_mem   [MAX_ENTRIES];
    logic [IW-1:0]     order_mem  [MAX_ENTRIES];
    logic [CW-1:0]     size_mem   [NB];
    logic [CW-1:0]     start_mem  [NB];
    logic [CW-1:0]     cursor_mem [NB];

    logic [CW-1:0]     entry_count_reg;
    logic              index_valid_reg;
    logic              out_valid_reg;

    logic [OP_W-1:0]   op_q_reg;
    logic [CODE_W-1:0] code_q_reg;
    logic [CW-1:0]     iter_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [CW-1:0]     acc_reg;
    logic [BKT_W-1:0]  key_reg;
    logic [CW-1:0]     slot_reg;
    logic [CW-1:0]     remain_reg;
    logic [CODE_W-1:0] code_rd_reg;
    logic [CW-1:0]     size_rd_reg;
    logic [CW-1:0]     start_rd_reg;
    logic [CW-1:0]     cur_rd_reg;
    logic [IW-1:0]     order_rd_reg;
    logic [ST_W-1:0]   status_reg;
    logic [INDEX_W-1:0] index_reg;

    logic [BKT_W-1:0]  rd_top;
    logic [BKT_W-1:0]  q_top;
    logic              code_re;
    logic [IW-1:0]     code_raddr;
    logic              size_we;
    logic [BKT_W-1:0]  size_waddr;
    logic [CW-1:0]     size_wdata;
    logic              size_re;
    logic [BKT_W-1:0]  size_raddr;
    logic              cursor_we;
    logic [BKT_W-1:0]  cursor_waddr;
    logic [CW-1:0]     cursor_wdata;

    assign rd_top = code_rd_reg[CODE_W-1 -: BKT_W];
    assign q_top  = code_q_reg[CODE_W-1 -: BKT_W];

    always_comb
    begin
        code_re    = (cmd.op == CMD_CNT_A) || (cmd.op == CMD_SCT_A) || (cmd.op == CMD_WK_B);
        code_raddr = (cmd.op == CMD_WK_B) ? order_rd_reg : iter_reg[IW-1:0];

        size_we    = (cmd.op == CMD_SWEEP) || (cmd.op == CMD_CNT_C);
        size_waddr = (cmd.op == CMD_SWEEP) ? bkt_reg : key_reg;
        size_wdata = (cmd.op == CMD_SWEEP) ? '0 : CW'(size_rd_reg + 1'b1);
        size_re    = (cmd.op == CMD_CNT_B) || (cmd.op == CMD_PFX_A) || (cmd.op == CMD_LK_A);
        priority if (cmd.op == CMD_CNT_B)
            size_raddr = rd_top;
        else if (cmd.op == CMD_PFX_A)
            size_raddr = bkt_reg;
        else
            size_raddr = q_top;

        cursor_we    = (cmd.op == CMD_PFX_B) || (cmd.op == CMD_SCT_C);
        cursor_waddr = (cmd.op == CMD_PFX_B) ? bkt_reg : key_reg;
        cursor_wdata = (cmd.op == CMD_PFX_B) ? acc_reg : CW'(cur_rd_reg + 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_APPEND)
            code_mem[entry_count_reg[IW-1:0]] <= code_q_reg;
        if (code_re)
            code_rd_reg <= code_mem[code_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_waddr] <= size_wdata;
        if (size_re)
            size_rd_reg <= size_mem[size_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_PFX_B)
            start_mem[bkt_reg] <= acc_reg;
        if (cmd.op == CMD_LK_A)
            start_rd_reg <= start_mem[q_top];
    end

    always_ff @(posedge clk)
    begin
        if (cursor_we)
            cursor_mem[cursor_waddr] <= cursor_wdata;
        if (cmd.op == CMD_SCT_B)
            cur_rd_reg <= cursor_mem[rd_top];
    end

    // buckets never overrun the table, so the slot always fits the index width
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_SCT_C)
            order_mem[cur_rd_reg[IW-1:0]] <= iter_reg[IW-1:0];
        if (cmd.op == CMD_WK_A)
            order_rd_reg <= order_mem[slot_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            index_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == CMD_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                CMD_CLEAR:
                begin
                    entry_count_reg <= '0;
                    index_valid_reg <= 1'b0;
                end
                CMD_APPEND:
                begin
                    entry_count_reg <= CW'(entry_count_reg + 1'b1);
                    index_valid_reg <= 1'b0;
                end
                CMD_BUILT:  index_valid_reg <= 1'b1;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            CMD_LOAD:
            begin
                op_q_reg   <= operation;
                code_q_reg <= code;
            end
            CMD_BKT_INIT: bkt_reg <= '0;
            CMD_SWEEP:
            begin
                bkt_reg  <= BKT_W'(bkt_reg + 1'b1);
                acc_reg  <= '0;
                iter_reg <= '0;
            end
            CMD_CNT_B:    key_reg  <= rd_top;
            CMD_CNT_C:    iter_reg <= CW'(iter_reg + 1'b1);
            CMD_PFX_A:    iter_reg <= '0;
            CMD_PFX_B:
            begin
                acc_reg <= CW'(acc_reg + size_rd_reg);
                bkt_reg <= BKT_W'(bkt_reg + 1'b1);
            end
            CMD_SCT_B:    key_reg  <= rd_top;
            CMD_SCT_C:    iter_reg <= CW'(iter_reg + 1'b1);
            CMD_LK_B:
            begin
                slot_reg   <= start_rd_reg;
                remain_reg <= size_rd_reg;
            end
            CMD_WK_NEXT:
            begin
                slot_reg   <= CW'(slot_reg + 1'b1);
                remain_reg <= CW'(remain_reg - 1'b1);
            end
            CMD_RESULT:
            begin
                status_reg <= cmd.res;
                index_reg  <= (cmd.res == ST_FOUND) ? INDEX_W'(order_rd_reg) : '0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.op          = op_q_reg;
        stat.full        = (entry_count_reg == CW'(MAX_ENTRIES));
        stat.index_valid = index_valid_reg;
        stat.bkt_last    = (bkt_reg == BKT_W'(NB - 1));
        stat.iter_end    = (iter_reg == entry_count_reg);
        stat.remain_zero = (remain_reg == '0);
        stat.match       = (code_rd_reg == code_q_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign index     = index_reg;

endmodule

`default_nettype wire

FILE: design/bctl_ctrl.sv
// Controller: sequences requests, index rebuild and bucket walk over the datapath.
`default_nettype none

module bctl_ctrl import bctl_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_CNT_CHK,
        S_CNT_A,
        S_CNT_B,
        S_CNT_C,
        S_PFX_A,
        S_PFX_B,
        S_SCT_CHK,
        S_SCT_A,
        S_SCT_B,
        S_SCT_C,
        S_LK_A,
        S_LK_B,
        S_WK_CHK,
        S_WK_A,
        S_WK_B,
        S_WK_C,
        S_RESP
    } state_t;

    state_t          state_reg;
    logic [ST_W-1:0] res_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            res_kind_reg <= ST_DONE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DECODE;
                S_DECODE:
                    unique case (stat.op)
                        OP_APPEND:
                        begin
                            res_kind_reg <= stat.full ? ST_FULL : ST_DONE;
                            state_reg    <= S_RESP;
                        end
                        OP_LOOKUP:
                            state_reg <= stat.index_valid ? S_LK_A : S_SWEEP;
                        default:
                        begin
                            res_kind_reg <= ST_DONE;
                            state_reg    <= S_RESP;
                        end
                    endcase
                S_SWEEP:
                    if (stat.bkt_last)
                        state_reg <= S_CNT_CHK;
                S_CNT_CHK: state_reg <= stat.iter_end ? S_PFX_A : S_CNT_A;
                S_CNT_A:   state_reg <= S_CNT_B;
                S_CNT_B:   state_reg <= S_CNT_C;
                S_CNT_C:   state_reg <= S_CNT_CHK;
                S_PFX_A:   state_reg <= S_PFX_B;
                S_PFX_B:   state_reg <= stat.bkt_last ? S_SCT_CHK : S_PFX_A;
                S_SCT_CHK: state_reg <= stat.iter_end ? S_LK_A : S_SCT_A;
                S_SCT_A:   state_reg <= S_SCT_B;
                S_SCT_B:   state_reg <= S_SCT_C;
                S_SCT_C:   state_reg <= S_SCT_CHK;
                S_LK_A:    state_reg <= S_LK_B;
                S_LK_B:    state_reg <= S_WK_CHK;
                S_WK_CHK:
                    if (stat.remain_zero)
                    begin
                        res_kind_reg <= ST_MISSING;
                        state_reg    <= S_RESP;
                    end
                    else
                        state_reg <= S_WK_A;
                S_WK_A:    state_reg <= S_WK_B;
                S_WK_B:    state_reg <= S_WK_C;
                S_WK_C:
                    if (stat.match)
                    begin
                        res_kind_reg <= ST_FOUND;
                        state_reg    <= S_RESP;
                    end
                    else
                        state_reg <= S_WK_CHK;
                S_RESP:
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.op   = CMD_NONE;
        cmd.res  = res_kind_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = CMD_LOAD;
            end
            S_DECODE:
                unique case (stat.op)
                    OP_CLEAR:  cmd.op = CMD_CLEAR;
                    OP_APPEND:
                        if (!stat.full)
                            cmd.op = CMD_APPEND;
                    OP_LOOKUP:
                        if (!stat.index_valid)
                            cmd.op = CMD_BKT_INIT;
                    default: ;
                endcase
            S_SWEEP:   cmd.op = CMD_SWEEP;
            S_CNT_A:   cmd.op = CMD_CNT_A;
            S_CNT_B:   cmd.op = CMD_CNT_B;
            S_CNT_C:   cmd.op = CMD_CNT_C;
            S_PFX_A:   cmd.op = CMD_PFX_A;
            S_PFX_B:   cmd.op = CMD_PFX_B;
            S_SCT_CHK:
                if (stat.iter_end)
                    cmd.op = CMD_BUILT;
            S_SCT_A:   cmd.op = CMD_SCT_A;
            S_SCT_B:   cmd.op = CMD_SCT_B;
            S_SCT_C:   cmd.op = CMD_SCT_C;
            S_LK_A:    cmd.op = CMD_LK_A;
            S_LK_B:    cmd.op = CMD_LK_B;
            S_WK_A:    cmd.op = CMD_WK_A;
            S_WK_B:    cmd.op = CMD_WK_B;
            S_WK_C:
                if (!stat.match)
                    cmd.op = CMD_WK_NEXT;
            S_RESP:
                if (stat.out_free)
                    cmd.op = CMD_RESULT;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/bucketed_code_table_lookup.sv
// Bucketed code table lookup: top level joining controller and datapath.
//
// Input channel (in_valid/in_ready, operation, code) carries one request:
// clear, append a 24-bit code, or look up the lowest index holding a code.
// Output channel (out_valid/out_ready, status, index) returns one result per
// request, in order. Requests are handled one at a time.
// The controller is ready for the next request in the cycle in which
// out_valid rises. A lookup with a current bucket index walks the entries of
// the code's bucket; each entry takes four steps: count check, order read,
// code read and compare.
// The first lookup after a clear or append rebuilds the index first:
// clearing all 256 bucket counts, counting entries per bucket, prefix sums
// and scattering.
// Reset empties the table and marks the index stale; memories are not
// cleared. A result waits in the output register while out_ready is low;
// the next request is still accepted, and its result is held back until the
// pending one has gone.
`default_nettype none

module bucketed_code_table_lookup import bctl_pkg::*; #(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [CODE_W-1:0]  code,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ST_W-1:0]         status,
    output logic [INDEX_W-1:0]      index
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bctl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bctl_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .operation (operation),
        .code      (code),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .status    (status),
        .index     (index)
    );

endmodule

`default_nettype wire

FILE: test/bucketed_code_table_lookup_tb.sv
// Testbench for the bucketed code table lookup: directed and random requests against a predictor.
`default_nettype none

module bucketed_code_table_lookup_tb;
    import bctl_pkg::*;

    localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [CODE_W-1:0] ASCII_PROBE = 24'h0000cc;
    localparam int RANDOM_ITEMS  = 820;
    localparam int LARGE_ENTRIES = 256;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [INDEX_W-1:0] index;
    } result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     operation;
    logic [CODE_W-1:0]   code;
    logic                out_valid;
    logic                out_ready;
    logic [ST_W-1:0]     status;
    logic [INDEX_W-1:0]  index;

    // predictor state: the codes held and how many
    logic [CODE_W-1:0]   held_codes [MAX_ENTRIES];
    int                  held_count = 0;

    result_t             pending_results [$];
    int unsigned         fails = 0;
    bit                  quiet = 1'b0;

    bucketed_code_table_lookup #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .code      (code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .index     (index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Walking the bucket in ascending index order finds the same first hit
    // as a plain scan from index zero, so a scan is all the predictor needs.
    function automatic result_t predict_result(input logic [OP_W-1:0] op,
                                               input logic [CODE_W-1:0] c);
        result_t r;
        int      i;
        bit      hit;
        r.status = ST_DONE;
        r.index  = '0;
        case (op)
            OP_CLEAR:
                held_count = 0;
            OP_APPEND:
                if (held_count >= MAX_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    held_codes[held_count] = c;
                    held_count++;
                end
            OP_LOOKUP:
            begin
                hit = 1'b0;
                i   = 0;
                while (!hit && i < held_count)
                begin
                    if (held_codes[i] == c)
                    begin
                        hit     = 1'b1;
                        r.index = i[INDEX_W-1:0];
                    end
                    i++;
                end
                r.status = hit ? ST_FOUND : ST_MISSING;
            end
            default: ;
        endcase
        return r;
    endfunction

    // half the codes take their top byte from four hot buckets so that buckets fill and codes repeat
    function automatic logic [CODE_W-1:0] fresh_code();
        logic [31:0]       r;
        logic [CODE_W-1:0] c;
        r = $urandom;
        c = r[23:0];
        if ($urandom_range(0, 1) == 0)
        begin
            case (r[25:24])
                2'd0: c[23:16] = 8'h00;
                2'd1: c[23:16] = 8'he4;
                2'd2: c[23:16] = 8'he9;
                default: c[23:16] = 8'hff;
            endcase
            if (r[28])
                c[15:0] = {14'd0, r[27:26]};
        end
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] lookup_code();
        logic [31:0]       r;
        logic [CODE_W-1:0] c;
        r = $urandom;
        c = r[23:0];
        case ($urandom_range(0, 5))
            0, 1, 2:
                if (held_count > 0)
                    c = held_codes[$urandom_range(0, held_count - 1)];
            3:
            begin
                // same bucket as a held code, most likely a miss
                if (held_count > 0)
                    c[23:16] = held_codes[$urandom_range(0, held_count - 1)][23:16];
            end
            4:
                c = ASCII_PROBE;
            default: ;
        endcase
        return c;
    endfunction

    // drive one request and hold it until accepted; valid stays high when no gap follows
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] c);
        int unsigned gap;
        in_valid  <= 1'b1;
        operation <= op;
        code      <= c;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_result(op, c));
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_request(OP_LOOKUP, 24'h000000);
        send_request(OP_LOOKUP, 24'hffffff);
        send_request(OP_LOOKUP, ASCII_PROBE);
        send_request(OP_UNUSED, 24'h000000);
        wait_for_results();
    endtask

    task automatic test_append_lookup();
        send_request(OP_APPEND, 24'h000000);
        send_request(OP_APPEND, 24'hffffff);
        send_request(OP_APPEND, ASCII_PROBE);
        send_request(OP_APPEND, 24'hffffff);
        send_request(OP_APPEND, 24'h00cc00);
        send_request(OP_LOOKUP, 24'hffffff);
        send_request(OP_LOOKUP, ASCII_PROBE);
        send_request(OP_LOOKUP, 24'h000000);
        send_request(OP_LOOKUP, 24'h00cc01);
        send_request(OP_LOOKUP, 24'h7f0000);
        send_request(OP_UNUSED, 24'hffffff);
        send_request(OP_LOOKUP, 24'h00cc00);
        // appending a duplicate makes the index stale; lowest index must still win
        send_request(OP_APPEND, ASCII_PROBE);
        send_request(OP_LOOKUP, ASCII_PROBE);
        wait_for_results();
    endtask

    task automatic test_clear();
        send_request(OP_CLEAR, 24'hffffff);
        send_request(OP_LOOKUP, ASCII_PROBE);
        send_request(OP_APPEND, ASCII_PROBE);
        send_request(OP_LOOKUP, ASCII_PROBE);
        send_request(OP_CLEAR, 24'h000000);
        wait_for_results();
    endtask

    task automatic test_large_table();
        int          i;
        logic [31:0] r;
        send_request(OP_CLEAR, 24'h000000);
        quiet = 1'b1;
        // unique codes packed into four buckets so that the walks run long
        for (i = 0; i < LARGE_ENTRIES; i++)
        begin
            r = $urandom;
            send_request(OP_APPEND, {6'd0, r[1:0], 3'b000, i[12:0]});
        end
        quiet = 1'b0;
        send_request(OP_LOOKUP, held_codes[LARGE_ENTRIES-1]);
        send_request(OP_LOOKUP, held_codes[0]);
        repeat (20) send_request(OP_LOOKUP, lookup_code());
        r = $urandom;
        send_request(OP_APPEND, r[23:0]);
        send_request(OP_LOOKUP, held_codes[LARGE_ENTRIES]);
        send_request(OP_CLEAR, 24'h000000);
        wait_for_results();
    endtask

    task automatic test_random_sequences();
        int unsigned counted;
        int unsigned k;
        logic [31:0] r;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any operation, any code
                repeat ($urandom_range(1, 6))
                begin
                    r = $urandom;
                    send_request(r[25:24], r[23:0]);
                    if (r[25:24] != OP_UNUSED)
                        counted++;
                end
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r = $urandom;
                    send_request(OP_CLEAR, r[23:0]);
                    counted++;
                end
                k = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(0, 24);
                repeat (k)
                begin
                    send_request(OP_APPEND, fresh_code());
                    counted++;
                end
                repeat ($urandom_range(1, 12))
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_request(OP_APPEND, fresh_code());
                    else
                        send_request(OP_LOOKUP, lookup_code());
                    counted++;
                end
            end
            if ($urandom_range(0, 11) == 0)
                wait_for_results();
        end
        quiet = 1'b0;
        wait_for_results();
    endtask

    // result side: random stalls, each result checked against the oldest expectation
    initial
    begin : result_check
        int unsigned stall;
        result_t     want;
        out_ready = 1'b0;
        stall     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d index %0d",
                             $time, status, index);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, status);
                        fails++;
                    end
                    if (index !== want.index)
                    begin
                        $display("%0t: index mismatch, expected %0d, got %0d",
                                 $time, want.index, index);
                        fails++;
                    end
                end
                stall = quiet ? 0 : $urandom_range(0, 8);
                if (stall != 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (stall <= 1)
                begin
                    out_ready <= 1'b1;
                    stall = 0;
                end
                else
                    stall--;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_CLEAR;
        code      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_append_lookup();
        test_clear();
        test_large_table();
        test_random_sequences();

        wait_for_results();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: bucketed_code_table_lookup.f
design/bctl_pkg.sv
design/bctl_dp.sv
design/bctl_ctrl.sv
design/bucketed_code_table_lookup.sv
test/bucketed_code_table_lookup_tb.sv
